### rtl/core/ltve_pkg.sv
`timescale 1ns / 1ps

package ltve_pkg;

  localparam int unsigned MaxTagChars = 8;
  localparam int unsigned NumberChars = 5;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSemi    = 8'h3B;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharNul     = 8'h00;

  localparam logic [15:0] NoTagValue   = 16'd255;
  localparam logic [7:0]  LineCountMax = 8'hFF;
  localparam logic [7:0]  MaxLineReset = 8'd32;

  typedef enum logic [1:0] {
    CFG_TAG_TEXT  = 2'd0,
    CFG_TAG_LEN   = 2'd1,
    CFG_MAX_LINE  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  // atoi scan phase over the captured characters
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } parse_phase_t;

endpackage

### rtl/core/line_tag_value_extractor_core.sv
`timescale 1ns / 1ps

// the item that closes a line loads its result into the output register or the skid entry
// throughput: one item per unstalled cycle; line state and number scan update once per item
// an output register with one skid entry behind it; the input stalls only while both hold a result
// reset (rst_n low, synchronous): line state and output queue cleared,
// tag_text 0, tag_length 0, max_line_length 32
module line_tag_value_extractor_core
  import ltve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sensor_value,
  output logic        out_tag_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] tag_text_r;
  logic [3:0]  tag_len_r;
  logic [7:0]  max_line_r;

  logic [63:0]  recent_r, recent_nxt;
  logic [7:0]   count_r, count_nxt;
  logic         ended_r, ended_nxt;
  logic         match_r, match_nxt;
  logic         cap_done_r, cap_done_nxt;
  logic [2:0]   cap_count_r, cap_count_nxt;
  parse_phase_t phase_r, phase_nxt;
  logic         neg_r, neg_nxt;
  logic [15:0]  val_r, val_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_value_r, out_value_nxt;
  logic        out_found_r, out_found_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [15:0] skid_value_r, skid_value_nxt;
  logic        skid_found_r, skid_found_nxt;

  logic [3:0]  tl;
  logic        tl_cut;
  logic [7:0]  limit;
  logic        accept;
  logic        pop;
  logic [7:0]  c;
  logic        m0;
  logic        capture;
  logic        emit;
  logic        emit_found;
  logic [15:0] emit_value;
  logic [15:0] parsed;
  logic        is_space;
  logic        is_digit;
  logic        is_sign;
  logic [15:0] digit;
  logic [6:0]  win_shift;
  logic [63:0] window;
  logic [63:0] mask;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid_r && !out_stall;
  assign c         = in_rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_text_r <= '0;
      tag_len_r  <= '0;
      max_line_r <= MaxLineReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TAG_TEXT: tag_text_r <= cfg_data;
        CFG_TAG_LEN:  tag_len_r  <= cfg_data[3:0];
        CFG_MAX_LINE: max_line_r <= cfg_data[7:0];
        CFG_UNUSED:   ;
        default:      ;
      endcase
    end
  end

  // tag length capped and cut at the first zero byte in the tag
  always_comb begin
    tl     = (tag_len_r > 4'(MaxTagChars)) ? 4'(MaxTagChars) : tag_len_r;
    tl_cut = 1'b0;
    for (int k = 0; k < MaxTagChars; k++) begin
      if (!tl_cut && (4'(k) < tl) && (tag_text_r[8*k +: 8] == CharNul)) begin
        tl     = 4'(k);
        tl_cut = 1'b1;
      end
    end
  end

  assign limit = (max_line_r >= 8'd2) ? max_line_r - 8'd1 : 8'd1;

  assign is_space = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  assign is_digit = (c >= CharZero) && (c <= CharNine);
  assign is_sign  = (c == CharPlus) || (c == CharMinus);
  assign digit    = {12'd0, 4'(c - CharZero)};

  assign m0 = match_r || ((tl == 4'd0) && (count_r == 8'd0) && !ended_r);

  // window over the recent bytes with the new byte shifted in
  assign win_shift = 7'd64 - {tl, 3'b000};
  assign window    = {c, recent_r[63:8]} >> win_shift;
  assign mask      = (tl >= 4'(MaxTagChars)) ? '1 : ((64'd1 << {tl, 3'b000}) - 64'd1);

  // scan phase: next-state logic, one captured character per item
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    val_nxt   = val_r;
    if (capture) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_digit) begin
            val_nxt   = digit;
            phase_nxt = PH_DIGITS;
          end else if (is_sign) begin
            neg_nxt   = (c == CharMinus);
            phase_nxt = PH_DIGITS;
          end else if (!is_space) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            val_nxt = (val_r << 3) + (val_r << 1) + digit;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: ;
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // scan output
  assign parsed = neg_nxt ? 16'd0 - val_nxt : val_nxt;

  always_comb begin
    recent_nxt    = recent_r;
    count_nxt     = count_r;
    ended_nxt     = ended_r;
    match_nxt     = m0;
    cap_done_nxt  = cap_done_r;
    cap_count_nxt = cap_count_r;
    capture       = 1'b0;
    emit          = 1'b0;

    if (c == CharNewline) begin
      emit = 1'b1;
    end else begin
      if (count_r != LineCountMax) begin
        count_nxt = count_r + 8'd1;
      end
      if (c == CharNul) begin
        ended_nxt = 1'b1;
      end else if (!ended_r) begin
        if (m0) begin
          if (!cap_done_r) begin
            if (c == CharSemi) begin
              cap_done_nxt = 1'b1;
            end else if (cap_count_r < 3'(NumberChars)) begin
              capture       = 1'b1;
              cap_count_nxt = cap_count_r + 3'd1;
              if (cap_count_nxt >= 3'(NumberChars)) begin
                cap_done_nxt = 1'b1;
              end
            end else begin
              cap_done_nxt = 1'b1;
            end
          end
        end else begin
          recent_nxt = {c, recent_r[63:8]};
          if ((tl != 4'd0) && (count_nxt >= {4'd0, tl}) &&
              ((window & mask) == (tag_text_r & mask))) begin
            match_nxt = 1'b1;
          end
        end
      end
      if (count_nxt >= limit) begin
        emit = 1'b1;
      end
    end
  end

  assign emit_found = match_nxt;
  assign emit_value = match_nxt ? parsed : NoTagValue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= '0;
      count_r     <= '0;
      ended_r     <= 1'b0;
      match_r     <= 1'b0;
      cap_done_r  <= 1'b0;
      cap_count_r <= '0;
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      val_r       <= '0;
    end else if (accept) begin
      if (emit) begin
        recent_r    <= '0;
        count_r     <= '0;
        ended_r     <= 1'b0;
        match_r     <= 1'b0;
        cap_done_r  <= 1'b0;
        cap_count_r <= '0;
        phase_r     <= PH_LEAD;
        neg_r       <= 1'b0;
        val_r       <= '0;
      end else begin
        recent_r    <= recent_nxt;
        count_r     <= count_nxt;
        ended_r     <= ended_nxt;
        match_r     <= match_nxt;
        cap_done_r  <= cap_done_nxt;
        cap_count_r <= cap_count_nxt;
        phase_r     <= phase_nxt;
        neg_r       <= neg_nxt;
        val_r       <= val_nxt;
      end
    end
  end

  // output register with a skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    skid_valid_nxt = skid_valid_r;
    skid_value_nxt = skid_value_r;
    skid_found_nxt = skid_found_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        out_value_nxt  = skid_value_r;
        out_found_nxt  = skid_found_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = emit_value;
        out_found_nxt = emit_found;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_value_nxt = emit_value;
        skid_found_nxt = emit_found;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    skid_value_r <= skid_value_nxt;
    skid_found_r <= skid_found_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_sensor_value = out_value_r;
  assign out_tag_found    = out_found_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_capture_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_count_r == 3'(NumberChars)) |-> cap_done_r)
    else $error("capture full but not closed");

  a_capture_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_count_r != 3'd0) |-> match_r)
    else $error("characters captured without a tag match");

  a_emit_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> (count_r == 8'd0) && !match_r && (cap_count_r == 3'd0))
    else $error("line state not cleared after a result");

endmodule

### tb/sv/line_tag_value_extractor_core_tb.sv
`timescale 1ns / 1ps

module line_tag_value_extractor_core_tb;
  import ltve_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [15:0] value;
    logic        found;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_TAG_TEXT;
  logic [63:0] cfg_data = '0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_sensor_value;
  logic        out_tag_found;
  logic        cfg_ready;

  line_tag_value_extractor_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sensor_value(out_sensor_value),
    .out_tag_found   (out_tag_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of registers and line state
  logic [63:0] tag_text_m;
  logic [3:0]  tag_len_m;
  logic [7:0]  max_line_m;
  logic [63:0] recent_m;
  int unsigned line_cnt_m;
  bit          text_end_m;
  bit          match_m;
  bit          cap_done_m;
  logic [7:0]  cap_m [NumberChars];
  int unsigned cap_cnt_m;

  reading_t    expected_readings[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_left = 0;

  function automatic void clear_line_state();
    recent_m = '0;
    line_cnt_m = 0;
    text_end_m = 1'b0;
    match_m = 1'b0;
    cap_done_m = 1'b0;
    cap_cnt_m = 0;
    for (int i = 0; i < NumberChars; i++) cap_m[i] = '0;
  endfunction

  // tag length capped and cut at the first zero byte of the tag
  function automatic int unsigned tag_chars_in_use();
    int unsigned n;
    n = tag_len_m;
    if (n > MaxTagChars) n = MaxTagChars;
    for (int unsigned k = 0; k < n; k++) begin
      if (tag_text_m[8*k +: 8] == CharNul) return k;
    end
    return n;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic logic [15:0] atoi_capture();
    int unsigned i;
    int unsigned n;
    logic [15:0] v;
    bit neg;
    i = 0;
    v = '0;
    neg = 1'b0;
    n = (cap_cnt_m > NumberChars) ? NumberChars : cap_cnt_m;
    while (i < n && is_blank(cap_m[i])) i++;
    if (i < n && (cap_m[i] == CharPlus || cap_m[i] == CharMinus)) begin
      neg = cap_m[i] == CharMinus;
      i++;
    end
    while (i < n && cap_m[i] >= CharZero && cap_m[i] <= CharNine) begin
      v = v * 16'd10 + 16'(cap_m[i] - CharZero);
      i++;
    end
    if (neg) v = -v;
    return v;
  endfunction

  function automatic void close_line();
    reading_t r;
    if (match_m) begin
      r.value = atoi_capture();
      r.found = 1'b1;
    end else begin
      r.value = NoTagValue;
      r.found = 1'b0;
    end
    expected_readings.push_back(r);
    clear_line_state();
  endfunction

  function automatic void predict_line_byte(logic [7:0] c);
    int unsigned tl;
    int unsigned limit;
    logic [63:0] mask;
    logic [63:0] window;
    tl = tag_chars_in_use();
    limit = (max_line_m >= 2) ? max_line_m - 1 : 1;
    // empty tag matches at the start of the line
    if (!match_m && tl == 0 && line_cnt_m == 0 && !text_end_m) match_m = 1'b1;
    if (c == CharNewline) begin
      close_line();
      return;
    end
    if (line_cnt_m < LineCountMax) line_cnt_m++;
    if (c == CharNul) begin
      text_end_m = 1'b1;
    end else if (!text_end_m) begin
      if (match_m) begin
        if (!cap_done_m) begin
          if (c == CharSemi) begin
            cap_done_m = 1'b1;
          end else if (cap_cnt_m < NumberChars) begin
            cap_m[cap_cnt_m] = c;
            cap_cnt_m++;
            if (cap_cnt_m >= NumberChars) cap_done_m = 1'b1;
          end else begin
            cap_done_m = 1'b1;
          end
        end
      end else begin
        recent_m = {c, recent_m[63:8]};
        if (tl >= 1 && line_cnt_m >= tl) begin
          mask = (tl >= 8) ? '1 : ((64'd1 << (8 * tl)) - 64'd1);
          window = recent_m >> (64 - 8 * tl);
          if ((window & mask) == (tag_text_m & mask)) match_m = 1'b1;
        end
      end
    end
    if (line_cnt_m >= limit) close_line();
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected item value %0d tag_found %0b", $time,
                 out_sensor_value, out_tag_found);
      end else begin
        want = expected_readings.pop_front();
        if (out_sensor_value !== want.value) begin
          errors++;
          $display("%0t: sensor_value expected %0d actual %0d", $time,
                   want.value, out_sensor_value);
        end
        if (out_tag_found !== want.found) begin
          errors++;
          $display("%0t: tag_found expected %0b actual %0b", $time,
                   want.found, out_tag_found);
        end
      end
    end
  end

  task automatic set_idle_mix(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line_byte(b);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // drop valid, let every pending reading arrive, then let a partial line settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TAG_TEXT: tag_text_m = val;
      CFG_TAG_LEN:  tag_len_m = val[3:0];
      CFG_MAX_LINE: max_line_m = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_config();
    logic [63:0] tt;
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(0, MaxTagChars);
    tt = {$urandom, $urandom};
    for (int unsigned k = 0; k < len; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) tt[8*k +: 8] = 8'($urandom_range(1, 255));
      else if (pick == 1) tt[8*k +: 8] = CharNul;
      else tt[8*k +: 8] = 8'($urandom_range(97, 122));
    end
    pick = $urandom_range(0, 15);
    if (pick == 0) tt = '1;
    else if (pick == 1) tt = '0;
    write_reg(CFG_TAG_TEXT, tt);
    write_reg(CFG_TAG_LEN,
              64'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : len));
    case ($urandom_range(0, 9))
      0: write_reg(CFG_MAX_LINE, 64'd0);
      1: write_reg(CFG_MAX_LINE, 64'd1);
      2: write_reg(CFG_MAX_LINE, 64'd2);
      3: write_reg(CFG_MAX_LINE, 64'd255);
      default: write_reg(CFG_MAX_LINE, 64'($urandom_range(6, 48)));
    endcase
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
  endtask

  // mostly tag + number lines, some cut-off tags and raw noise
  task automatic send_line();
    int unsigned kind;
    int unsigned tl;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(97, 122)));
      tl = tag_chars_in_use();
      n = (kind == 1 && tl > 0) ? $urandom_range(0, tl - 1) : tl;
      for (int unsigned k = 0; k < n; k++) push_byte(tag_text_m[8*k +: 8]);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) != 0) push_byte(CharSpace);
        else push_byte(8'($urandom_range(CharTab, CharCr)));
      end
      case ($urandom_range(0, 3))
        0: push_byte(CharMinus);
        1: push_byte(CharPlus);
        default: ;
      endcase
      repeat ($urandom_range(0, 6)) push_byte(CharZero + 8'($urandom_range(0, 9)));
      case ($urandom_range(0, 5))
        0: push_byte(CharSemi);
        1: push_byte(CharNul);
        2: push_byte(8'($urandom_range(97, 122)));
        default: ;
      endcase
    end
    if ($urandom_range(0, 7) != 0) push_byte(CharNewline);
  endtask

  task automatic test_parse_cases();
    set_idle_mix(0, 0);
    // zero byte in the tag cuts it to one char, length field above the cap
    write_reg(CFG_TAG_TEXT, 64'hFFFF_FFFF_FFFF_0074);
    write_reg(CFG_TAG_LEN, 64'hF);
    write_reg(CFG_MAX_LINE, 64'(MaxLineReset));
    write_reg(CFG_UNUSED, '1);
    push_text("t-7");
    push_byte(CharNewline);
    push_text("x");
    push_byte(8'hFF);
    push_byte(CharNewline);
    push_text("t99999");
    push_byte(CharNewline);
    // text ends before the tag
    push_byte(CharNul);
    push_text("t5");
    push_byte(CharNewline);
    // empty tag on an empty line
    wait_idle();
    write_reg(CFG_TAG_LEN, 64'd0);
    push_byte(CharNewline);
    wait_idle();
    write_reg(CFG_MAX_LINE, 64'd1);
    push_text("a");
    wait_idle();
    write_reg(CFG_MAX_LINE, 64'd0);
    push_text("7");
    // limit lowered below the current line length
    wait_idle();
    write_reg(CFG_MAX_LINE, 64'd255);
    push_text("abc");
    wait_idle();
    write_reg(CFG_MAX_LINE, 64'd2);
    push_text("d");
    wait_idle();
  endtask

  task automatic test_output_holdoff();
    set_idle_mix(0, 0);
    write_reg(CFG_MAX_LINE, 64'(MaxLineReset));
    hold_left = HoldCycles;
    repeat (40) push_byte(CharNewline);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idle_mix(0, 0);
        1: set_idle_mix(59, 0);
        2: set_idle_mix(0, 59);
        default: set_idle_mix(27, 27);
      endcase
      stop_at = bytes_sent + 250;
      while (bytes_sent < stop_at) begin
        wait_idle();
        rand_config();
        repeat ($urandom_range(3, 10)) send_line();
      end
    end
    wait_idle();
  endtask

  initial begin
    tag_text_m = '0;
    tag_len_m = '0;
    max_line_m = MaxLineReset;
    clear_line_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_parse_cases();
    test_output_holdoff();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
